FILE: hdl/ssca_pkg.sv
// Shared types, codes and constants for the slab size-class allocator.
// No dependencies; imported by every module of the block.
package ssca_pkg;

   localparam int NUM_CLASSES_DEF = 10;
   localparam int SLAB_SLOTS_DEF  = 16;
   localparam int SLAB_BYTES_DEF  = 65536;
   localparam int MAX_OBJECTS_DEF = 1364;

   localparam int WORD_W     = 64;
   localparam int SIZE_W     = 32;
   localparam int CLS_W      = 4;
   localparam int CLS_N      = 16;
   localparam int STRIDE_W   = 21;
   localparam int STAT_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 72;

   localparam int SLAB_HDR_BYTES  = 64;
   localparam int OBJ_HDR_BYTES   = 16;
   localparam int MIN_CLASS_BYTES = 32;

   typedef enum logic [STAT_W-1:0] {
      STAT_ALLOC,
      STAT_FREED,
      STAT_ZERO,
      STAT_PASS,
      STAT_NOSLAB,
      STAT_DOUBLE,
      STAT_OUTSIDE
   } ssca_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_BASE,
      CSR_HEAP_LOWER,
      CSR_HEAP_UPPER
   } ssca_csr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ASCAN,
      S_ACLAIM,
      S_APOP,
      S_AMUL,
      S_ASUM,
      S_ACHK,
      S_FSCAN,
      S_FCHK,
      S_FDIV,
      S_FMARK,
      S_DONE
   } ssca_state_type;

   typedef struct packed {
      logic stk_we;
      logic mark_we;
      logic mark_wd;
   } ssca_mem_ctl_type;

   function automatic logic [STRIDE_W-1:0] class_stride(input logic [CLS_W-1:0] cls);
      return (STRIDE_W'(MIN_CLASS_BYTES) << cls) + STRIDE_W'(OBJ_HDR_BYTES);
   endfunction

endpackage

FILE: hdl/slab_size_class_allocator_core.sv
// Slab allocator top: request sequencer, slot table, class tables.
// Depends on ssca_pkg, ssca_store and ssca_div.
//
//  channel | direction | payload
//  req     | in        | tuser: kind; tdata: request_size, object_address
//  rsp     | out       | tuser: status; tdata: result_address, size_class
//  csr     | in        | csr_index, csr_wdata (3 x 64-bit registers)
//
// One request at a time. Allocate: a newest-first slot scan (up to SLAB_SLOTS
// slots), a claim if none fits, then pop, multiply, sum and check. Free: an
// address scan over every claimed slot, then, for a candidate, a divide and a mark update.
// Reset is synchronous; slot table clears at once, stack and marks need no pass.
// A waiting response does not block the next request; the sequencer stalls
// only when a second response is ready before the first is taken.
module slab_size_class_allocator_core #(
   parameter int NUM_CLASSES = ssca_pkg::NUM_CLASSES_DEF,
   parameter int SLAB_SLOTS  = ssca_pkg::SLAB_SLOTS_DEF,
   parameter int SLAB_BYTES  = ssca_pkg::SLAB_BYTES_DEF,
   parameter int MAX_OBJECTS = ssca_pkg::MAX_OBJECTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [95:32] object_address, [31:0] request_size
   input  logic [ssca_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] kind
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [71:68] zero, [67:64] size_class, [63:0] result_address
   output logic [ssca_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [2:0] status
   output logic [ssca_pkg::STAT_W-1:0]     rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ssca_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssca_pkg::WORD_W-1:0]     csr_wdata
);
   import ssca_pkg::*;

   localparam int OFF_W  = $clog2(SLAB_BYTES);
   localparam int OBJ_W  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
   localparam int CNT_W  = $clog2(MAX_OBJECTS + 1);
   localparam int SLOT_W = (SLAB_SLOTS > 1) ? $clog2(SLAB_SLOTS) : 1;
   localparam int CLM_W  = $clog2(SLAB_SLOTS + 1);
   localparam int DEPTH  = SLAB_SLOTS * MAX_OBJECTS;
   localparam int MEM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_W = OBJ_W + STRIDE_W;

   // per-class object count and used span, fixed at elaboration
   logic [CNT_W-1:0] cls_objs [CLS_N];
   logic [OFF_W-1:0] cls_span [CLS_N];

   for (genvar c = 0; c < CLS_N; c++) begin : g_cls
      localparam int STR  = (MIN_CLASS_BYTES << c) + OBJ_HDR_BYTES;
      localparam int NRAW = (SLAB_BYTES > SLAB_HDR_BYTES) ?
                            (SLAB_BYTES - SLAB_HDR_BYTES) / STR : 0;
      localparam int NOBJ = (NRAW > MAX_OBJECTS) ? MAX_OBJECTS : NRAW;
      assign cls_objs[c] = CNT_W'(NOBJ);
      assign cls_span[c] = OFF_W'(NOBJ * STR);
   end

   ssca_state_type   state_ff, state_in;
   logic [WORD_W-1:0] region_ff, region_in, lower_ff, lower_in, upper_ff, upper_in;
   logic [CLS_W-1:0]  owner_ff [SLAB_SLOTS];
   logic [CLS_W-1:0]  owner_in [SLAB_SLOTS];
   logic [CNT_W-1:0]  count_ff [SLAB_SLOTS];
   logic [CNT_W-1:0]  count_in [SLAB_SLOTS];
   // lowest stack depth since claim; stack entries below it still hold their index
   logic [CNT_W-1:0]  minc_ff [SLAB_SLOTS];
   logic [CNT_W-1:0]  minc_in [SLAB_SLOTS];
   logic [CLM_W-1:0]  claimed_ff, claimed_in;
   logic [CLS_W-1:0]  cls_ff, cls_in;
   logic [SLOT_W-1:0] slot_ff, slot_in, sc_ff, sc_in, cand_ff, cand_in;
   logic              cand_vld_ff, cand_vld_in;
   logic [OFF_W-1:0]  cand_off_ff, cand_off_in;
   logic [OBJ_W-1:0]  obj_ff, obj_in;
   logic              from_mem_ff, from_mem_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [WORD_W-1:0] tbase_ff, tbase_in, res_ff, res_in;
   logic [WORD_W-1:0] cur_base_ff, cur_base_in, cur_off_ff, cur_off_in;
   logic [CLS_N-1:0]  oc_any_ff, oc_any_in;
   logic [SLOT_W-1:0] oc_max_ff [CLS_N];
   logic [SLOT_W-1:0] oc_max_in [CLS_N];
   ssca_status_type   stat_ff, stat_in, rsp_stat_ff, rsp_stat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [CLS_W-1:0]  rsp_cls_ff, rsp_cls_in;

   logic              req_fire, out_free;
   logic              req_kind;
   logic [SIZE_W-1:0] req_size;
   logic [WORD_W-1:0] req_addr;
   logic [CLS_W-1:0]  size_cls;
   logic              size_hit;
   logic              scan_hit, claim_full, scan_last, base_ok, off_match;
   logic              chk_bad, res_ok, mark_set;
   logic [SLOT_W-1:0] claim_slot;
   logic [CNT_W-1:0]  new_n, pop_idx;
   logic [OBJ_W-1:0]  obj_rd;
   logic [CLS_W-1:0]  cand_cls;
   logic [WORD_W-1:0] res_hdr;

   ssca_mem_ctl_type  mem_ctl;
   logic [MEM_AW-1:0] stk_addr, mark_addr;
   logic [OBJ_W-1:0]  stk_rdata;
   logic              mark_rdata;
   logic              div_start, div_done, div_rem_zero;
   logic [OBJ_W-1:0]  div_quot;

   function automatic logic [MEM_AW-1:0] mem_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [CNT_W-1:0] k);
      return MEM_AW'(s) * MEM_AW'(MAX_OBJECTS) + MEM_AW'(k);
   endfunction

   function automatic logic in_heap(input logic [WORD_W-1:0] a,
                                    input logic [WORD_W-1:0] lo,
                                    input logic [WORD_W-1:0] hi);
      return (a >= lo) && (a < hi);
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_kind   = req_tuser[0];
   assign req_size   = req_tdata[SIZE_W-1:0];
   assign req_addr   = req_tdata[SIZE_W +: WORD_W];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      size_cls = '0;
      size_hit = 1'b0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if ({1'b0, req_size} <= ((SIZE_W + 1)'(MIN_CLASS_BYTES) << c)) begin
            size_cls = CLS_W'(c);
            size_hit = 1'b1;
         end
      end
   end

   assign scan_hit   = (owner_ff[sc_ff] == cls_ff) && (count_ff[sc_ff] != '0);
   assign claim_full = (claimed_ff >= CLM_W'(SLAB_SLOTS));
   assign claim_slot = SLOT_W'(claimed_ff);
   assign new_n      = cls_objs[cls_ff];
   assign pop_idx    = count_ff[slot_ff] - CNT_W'(1);
   assign obj_rd     = !from_mem_ff ? obj_ff :
                       (CNT_W'(stk_rdata) >= CNT_W'(MAX_OBJECTS)) ? '0 : stk_rdata;
   assign res_hdr    = res_ff - WORD_W'(OBJ_HDR_BYTES);
   assign res_ok     = in_heap(res_hdr, lower_ff, upper_ff) && in_heap(res_ff, lower_ff, upper_ff);
   assign scan_last  = (CLM_W'(sc_ff) + CLM_W'(1)) == claimed_ff;
   assign base_ok    = in_heap(cur_base_ff, lower_ff, upper_ff);
   assign off_match  = cur_off_ff < WORD_W'(cls_span[owner_ff[sc_ff]]);
   assign cand_cls   = owner_ff[cand_ff];
   assign mark_set   = (CNT_W'(obj_ff) >= minc_ff[slot_ff]) && mark_rdata;

   // an out-of-heap slot of a lower class, or of the candidate's from it up, means a pass
   always_comb begin
      chk_bad = oc_any_ff[cand_cls] && (oc_max_ff[cand_cls] >= cand_ff);
      for (int c = 0; c < CLS_N; c++) begin
         if (oc_any_ff[c] && (CLS_W'(c) < cand_cls)) begin
            chk_bad = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_kind) begin
                  state_in = ((req_addr == '0) || (claimed_ff == '0)) ? S_DONE : S_FSCAN;
               end else if ((req_size == '0) || !size_hit) begin
                  state_in = S_DONE;
               end else begin
                  state_in = (claimed_ff == '0) ? S_ACLAIM : S_ASCAN;
               end
            end
         end
         S_ASCAN: begin
            if (scan_hit) begin
               state_in = S_APOP;
            end else if (sc_ff == '0) begin
               state_in = S_ACLAIM;
            end
         end
         S_ACLAIM: state_in = (claim_full || (new_n == '0)) ? S_DONE : S_APOP;
         S_APOP:   state_in = S_AMUL;
         S_AMUL:   state_in = S_ASUM;
         S_ASUM:   state_in = S_ACHK;
         S_ACHK:   state_in = S_DONE;
         S_FSCAN: begin
            if (scan_last) begin
               state_in = S_FCHK;
            end
         end
         S_FCHK:   state_in = (!cand_vld_ff || chk_bad) ? S_DONE : S_FDIV;
         S_FDIV: begin
            if (div_done) begin
               state_in = div_rem_zero ? S_FMARK : S_DONE;
            end
         end
         S_FMARK:  state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      region_in    = region_ff;
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      owner_in     = owner_ff;
      count_in     = count_ff;
      minc_in      = minc_ff;
      claimed_in   = claimed_ff;
      cls_in       = cls_ff;
      slot_in      = slot_ff;
      sc_in        = sc_ff;
      cand_in      = cand_ff;
      cand_vld_in  = cand_vld_ff;
      cand_off_in  = cand_off_ff;
      obj_in       = obj_ff;
      from_mem_in  = from_mem_ff;
      prod_in      = prod_ff;
      tbase_in     = tbase_ff;
      res_in       = res_ff;
      cur_base_in  = cur_base_ff;
      cur_off_in   = cur_off_ff;
      oc_any_in    = oc_any_ff;
      oc_max_in    = oc_max_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_cls_in   = rsp_cls_ff;
      mem_ctl      = '0;
      div_start    = 1'b0;
      stk_addr     = mem_addr(slot_ff, pop_idx);
      mark_addr    = mem_addr(slot_ff, CNT_W'(obj_ff));

      if (csr_valid && csr_ready) begin
         priority case (csr_index)
            CSR_REGION_BASE: region_in = csr_wdata;
            CSR_HEAP_LOWER:  lower_in  = csr_wdata;
            CSR_HEAP_UPPER:  upper_in  = csr_wdata;
            default:         ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cls_in      = size_cls;
               sc_in       = req_kind ? '0 : SLOT_W'(claimed_ff - CLM_W'(1));
               cur_base_in = region_ff;
               cur_off_in  = req_addr - region_ff - WORD_W'(SLAB_HDR_BYTES + OBJ_HDR_BYTES);
               cand_vld_in = 1'b0;
               oc_any_in   = '0;
               if (req_kind || !size_hit) begin
                  stat_in = STAT_PASS;
               end else if (req_size == '0) begin
                  stat_in = STAT_ZERO;
               end
            end
         end
         S_ASCAN: begin
            if (scan_hit) begin
               slot_in = sc_ff;
            end else begin
               sc_in = sc_ff - SLOT_W'(1);
            end
         end
         S_ACLAIM: begin
            if (claim_full) begin
               stat_in = STAT_NOSLAB;
            end else begin
               owner_in[claim_slot] = cls_ff;
               count_in[claim_slot] = new_n;
               minc_in[claim_slot]  = new_n;
               claimed_in           = claimed_ff + CLM_W'(1);
               slot_in              = claim_slot;
               if (new_n == '0) begin
                  stat_in = STAT_NOSLAB;
               end
            end
         end
         S_APOP: begin
            // untouched part of a fresh stack holds object k at depth k
            if (pop_idx < minc_ff[slot_ff]) begin
               obj_in      = OBJ_W'(pop_idx);
               from_mem_in = 1'b0;
            end else begin
               from_mem_in = 1'b1;
            end
         end
         S_AMUL: begin
            obj_in   = obj_rd;
            prod_in  = PROD_W'(obj_rd) * PROD_W'(class_stride(cls_ff));
            tbase_in = region_ff + WORD_W'(slot_ff) * WORD_W'(SLAB_BYTES);
         end
         S_ASUM: begin
            res_in = tbase_ff + WORD_W'(prod_ff) + WORD_W'(SLAB_HDR_BYTES + OBJ_HDR_BYTES);
         end
         S_ACHK: begin
            if (res_ok) begin
               count_in[slot_ff] = pop_idx;
               if (pop_idx < minc_ff[slot_ff]) begin
                  minc_in[slot_ff] = pop_idx;
               end
               mem_ctl.mark_we = 1'b1;
               mem_ctl.mark_wd = 1'b1;
               stat_in         = STAT_ALLOC;
            end else begin
               stat_in = STAT_OUTSIDE;
            end
         end
         S_FSCAN: begin
            if (!base_ok) begin
               oc_any_in[owner_ff[sc_ff]] = 1'b1;
               oc_max_in[owner_ff[sc_ff]] = sc_ff;
            end
            if (off_match) begin
               cand_in     = sc_ff;
               cand_vld_in = 1'b1;
               cand_off_in = OFF_W'(cur_off_ff);
            end
            cur_base_in = cur_base_ff + WORD_W'(SLAB_BYTES);
            cur_off_in  = cur_off_ff - WORD_W'(SLAB_BYTES);
            sc_in       = sc_ff + SLOT_W'(1);
         end
         S_FCHK: begin
            cls_in  = cand_cls;
            slot_in = cand_ff;
            if (cand_vld_ff && !chk_bad) begin
               div_start = 1'b1;
            end
         end
         S_FDIV: begin
            mark_addr = mem_addr(slot_ff, CNT_W'(div_quot));
            if (div_done) begin
               obj_in = div_quot;
            end
         end
         S_FMARK: begin
            stk_addr = mem_addr(slot_ff, count_ff[slot_ff]);
            if (mark_set) begin
               mem_ctl.mark_we = 1'b1;
               mem_ctl.mark_wd = 1'b0;
               if (count_ff[slot_ff] < CNT_W'(MAX_OBJECTS)) begin
                  mem_ctl.stk_we    = 1'b1;
                  count_in[slot_ff] = count_ff[slot_ff] + CNT_W'(1);
               end
               stat_in = STAT_FREED;
            end else begin
               stat_in = STAT_DOUBLE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = stat_ff;
               rsp_addr_in  = (stat_ff == STAT_ALLOC) ? res_ff : '0;
               rsp_cls_in   = ((stat_ff == STAT_ZERO) || (stat_ff == STAT_PASS)) ? '0 : cls_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         region_ff    <= '0;
         lower_ff     <= '0;
         upper_ff     <= '1;
         claimed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SLAB_SLOTS; s++) begin
            owner_ff[s] <= '0;
            count_ff[s] <= '0;
            minc_ff[s]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         region_ff    <= region_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         claimed_ff   <= claimed_in;
         rsp_valid_ff <= rsp_valid_in;
         owner_ff     <= owner_in;
         count_ff     <= count_in;
         minc_ff      <= minc_in;
      end
      cls_ff      <= cls_in;
      slot_ff     <= slot_in;
      sc_ff       <= sc_in;
      cand_ff     <= cand_in;
      cand_vld_ff <= cand_vld_in;
      cand_off_ff <= cand_off_in;
      obj_ff      <= obj_in;
      from_mem_ff <= from_mem_in;
      prod_ff     <= prod_in;
      tbase_ff    <= tbase_in;
      res_ff      <= res_in;
      cur_base_ff <= cur_base_in;
      cur_off_ff  <= cur_off_in;
      oc_any_ff   <= oc_any_in;
      oc_max_ff   <= oc_max_in;
      stat_ff     <= stat_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_cls_ff  <= rsp_cls_in;
   end

   ssca_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (MEM_AW),
      .DATA_W (OBJ_W)
   ) u_store (
      .clock      (clock),
      .mem_ctl    (mem_ctl),
      .stk_addr   (stk_addr),
      .stk_wdata  (obj_ff),
      .stk_rdata  (stk_rdata),
      .mark_addr  (mark_addr),
      .mark_rdata (mark_rdata)
   );

   ssca_div #(
      .OFF_W  (OFF_W),
      .QUOT_W (OBJ_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cand_off_ff),
      .divisor  (class_stride(cand_cls)),
      .done     (div_done),
      .quot     (div_quot),
      .rem_zero (div_rem_zero)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - WORD_W - CLS_W)'(0), rsp_cls_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_stat_ff;

endmodule

FILE: hdl/ssca_store.sv
// Free-stack and allocated-mark memories with registered reads.
// Depends on ssca_pkg for the control struct.
module ssca_store #(
   parameter int DEPTH  = 21824,
   parameter int ADDR_W = 15,
   parameter int DATA_W = 11
) (
   input  logic                       clock,
   input  ssca_pkg::ssca_mem_ctl_type mem_ctl,
   input  logic [ADDR_W-1:0]          stk_addr,
   input  logic [DATA_W-1:0]          stk_wdata,
   output logic [DATA_W-1:0]          stk_rdata,
   input  logic [ADDR_W-1:0]          mark_addr,
   output logic                       mark_rdata
);
   import ssca_pkg::*;

   logic [DATA_W-1:0] stk_mem [DEPTH];
   logic              mark_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_ctl.stk_we) begin
         stk_mem[stk_addr] <= stk_wdata;
      end
      stk_rdata <= stk_mem[stk_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.mark_we) begin
         mark_mem[mark_addr] <= mem_ctl.mark_wd;
      end
      mark_rdata <= mark_mem[mark_addr];
   end

endmodule

FILE: hdl/ssca_div.sv
// Restoring divider, one quotient bit per cycle; splits a slab offset into
// object number and a zero-remainder flag. Depends on ssca_pkg for the stride width.
module ssca_div #(
   parameter int OFF_W  = 16,
   parameter int QUOT_W = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [OFF_W-1:0]              dividend,
   input  logic [ssca_pkg::STRIDE_W-1:0] divisor,
   output logic                          done,
   output logic [QUOT_W-1:0]             quot,
   output logic                          rem_zero
);
   import ssca_pkg::*;

   localparam int REM_W = ((OFF_W > STRIDE_W + QUOT_W) ? OFF_W : STRIDE_W + QUOT_W) + 1;
   localparam int BIT_W = (QUOT_W > 1) ? $clog2(QUOT_W) : 1;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [STRIDE_W-1:0] dsr_ff, dsr_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic [REM_W-1:0]    shifted;

   assign shifted = REM_W'(dsr_ff) << bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = BIT_W'(QUOT_W - 1);
         rem_in  = REM_W'(dividend);
         dsr_in  = divisor;
         quot_in = '0;
      end else if (busy_ff) begin
         if (rem_ff >= shifted) begin
            rem_in          = rem_ff - shifted;
            quot_in[bit_ff] = 1'b1;
         end
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - BIT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quot     = quot_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

FILE: test/tb.sv
// Testbench for slab_size_class_allocator_core: directed, register, random request and back-pressure tests.
// Depends on ssca_pkg and the RTL; it carries its own allocator model to check each response.
module tb;
   import ssca_pkg::*;

   localparam int CLASSES = NUM_CLASSES_DEF;
   localparam int SLOTS   = SLAB_SLOTS_DEF;
   localparam int SLAB_SZ = SLAB_BYTES_DEF;
   localparam int OBJ_MAX = MAX_OBJECTS_DEF;
   localparam logic [63:0] ALL_ONES = '1;

   typedef struct packed {
      ssca_status_type st;
      logic [63:0]     addr;
      logic [3:0]      cls;
   } alloc_outcome_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0] csr_wdata = '0;

   slab_size_class_allocator_core dut (.*);

   always #1 clock = ~clock;

   // allocator model state
   logic [63:0] region_base, heap_lo, heap_hi;
   logic [3:0]  slot_cls [SLOTS];
   int          slot_cnt [SLOTS];
   int          claimed;
   logic [10:0] obj_stack [SLOTS][OBJ_MAX];
   bit          obj_live [SLOTS][OBJ_MAX];

   alloc_outcome_t pending_rsp[$];
   logic [63:0] live_off[$];
   logic [63:0] freed_off[$];
   int snd_idle = 0, rcv_idle = 0, hold_left = 0;
   int n_rsp = 0, n_req = 0;
   bit failed = 1'b0;

   function automatic logic [63:0] cls_stride(int c);
      return (64'd32 << c) + 64'd16;
   endfunction

   function automatic logic [63:0] cls_objs(int c);
      logic [63:0] n;
      n = 64'(SLAB_SZ - SLAB_HDR_BYTES) / cls_stride(c);
      return (n > OBJ_MAX) ? 64'(OBJ_MAX) : n;
   endfunction

   function automatic bit in_heap(logic [63:0] a);
      return a >= heap_lo && a < heap_hi;
   endfunction

   function automatic logic [63:0] slot_addr(int s);
      return region_base + 64'(s) * 64'(SLAB_SZ);
   endfunction

   function automatic alloc_outcome_t model_alloc(logic [31:0] size);
      alloc_outcome_t r;
      int c, s, k;
      bit found;
      logic [63:0] n, obj, res;
      r = '{STAT_ZERO, 64'd0, 4'd0};
      found = 1'b0;
      if (size == 0) return r;
      for (c = 0; c < CLASSES; c++)
         if (64'(size) <= (64'd32 << c)) break;
      r.st = STAT_PASS;
      if (c >= CLASSES) return r;
      r.cls = 4'(c);
      for (s = claimed - 1; s >= 0; s--)
         if (slot_cls[s] == 4'(c) && slot_cnt[s] > 0) begin
            found = 1'b1;
            break;
         end
      if (!found) begin
         r.st = STAT_NOSLAB;
         if (claimed >= SLOTS) return r;
         s = claimed++;
         n = cls_objs(c);
         slot_cls[s] = 4'(c);
         slot_cnt[s] = int'(n);
         for (k = 0; k < OBJ_MAX; k++) begin
            obj_stack[s][k] = 11'(k);
            obj_live[s][k] = 1'b0;
         end
         if (n == 0) return r;
      end
      obj = 64'(obj_stack[s][slot_cnt[s] - 1]);
      if (obj >= OBJ_MAX) obj = 0;
      res = slot_addr(s) + 64'd64 + obj * cls_stride(c) + 64'd16;
      if (!in_heap(res - 64'd16) || !in_heap(res)) begin
         r.st = STAT_OUTSIDE;
         return r;
      end
      slot_cnt[s]--;
      obj_live[s][obj] = 1'b1;
      r.st = STAT_ALLOC;
      r.addr = res;
      return r;
   endfunction

   function automatic alloc_outcome_t model_free(logic [63:0] addr);
      alloc_outcome_t r;
      int c, s;
      logic [63:0] hdr, base, off, stride, obj;
      r = '{STAT_PASS, 64'd0, 4'd0};
      if (addr == 0) return r;
      hdr = addr - 64'd16;
      for (c = 0; c < CLASSES; c++)
         for (s = claimed - 1; s >= 0; s--) begin
            if (slot_cls[s] != 4'(c)) continue;
            base = slot_addr(s);
            if (!in_heap(base)) return r;
            stride = cls_stride(c);
            off = hdr - (base + 64'd64);
            if (off >= cls_objs(c) * stride) continue;
            if (off % stride != 0) return r;
            obj = off / stride;
            r.cls = 4'(c);
            if (!obj_live[s][obj]) begin
               r.st = STAT_DOUBLE;
               return r;
            end
            obj_live[s][obj] = 1'b0;
            if (slot_cnt[s] < OBJ_MAX) begin
               obj_stack[s][slot_cnt[s]] = 11'(obj);
               slot_cnt[s]++;
            end
            r.st = STAT_FREED;
            return r;
         end
      return r;
   endfunction

   // drive one request; the model runs at hand-off since requests complete in order
   task automatic send_req(bit is_free, logic [31:0] size, logic [63:0] addr);
      alloc_outcome_t r;
      while ($urandom_range(99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= is_free;
      req_tdata <= {addr, size};
      r = is_free ? model_free(addr) : model_alloc(size);
      if (r.st == STAT_ALLOC) live_off.push_back(r.addr - region_base);
      pending_rsp.push_back(r);
      n_req++;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_regs(logic [63:0] base, logic [63:0] lo, logic [63:0] hi);
      ssca_csr_type idx;
      logic [63:0] val;
      for (int i = 0; i < 3; i++) begin
         idx = ssca_csr_type'(i);
         val = (idx == CSR_REGION_BASE) ? base : (idx == CSR_HEAP_LOWER) ? lo : hi;
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= val;
         do @(negedge clock); while (!csr_ready);
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      region_base = base;
      heap_lo = lo;
      heap_hi = hi;
   endtask

   task automatic free_live(int idx);
      logic [63:0] off;
      off = live_off[idx];
      live_off.delete(idx);
      freed_off.push_back(off);
      if (freed_off.size() > 64) void'(freed_off.pop_front());
      send_req(1'b1, 32'd0, region_base + off);
   endtask

   // response checker and receiver stall
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else
         rsp_tready <= ($urandom_range(99) >= rcv_idle);
   end

   always @(negedge clock) begin
      alloc_outcome_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_rsp++;
         if (pending_rsp.size() == 0) begin
            $error("response with nothing outstanding");
            failed = 1'b1;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_tuser !== e.st) begin
               $error("status: expected %0d got %0d", e.st, rsp_tuser);
               failed = 1'b1;
            end
            if (rsp_tdata[63:0] !== e.addr) begin
               $error("result_address: expected %h got %h", e.addr, rsp_tdata[63:0]);
               failed = 1'b1;
            end
            if (rsp_tdata[67:64] !== e.cls) begin
               $error("size_class: expected %0d got %0d", e.cls, rsp_tdata[67:64]);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic test_directed();
      write_regs(64'h0000_1000_0000_0000, 64'd0, ALL_ONES);
      send_req(1'b0, 32'd0, 64'd0);
      send_req(1'b0, 32'd16385, 64'd0);
      send_req(1'b0, 32'hFFFF_FFFF, ALL_ONES);
      for (int c = 0; c < CLASSES; c++) send_req(1'b0, 32'd32 << c, 64'd0);
      send_req(1'b0, 32'd1, 64'd0);
      send_req(1'b1, 32'd0, 64'd0);                                // address zero
      send_req(1'b1, 32'd0, 64'h0000_2000_0000_0000);              // in no slab
      send_req(1'b1, 32'hFFFF_FFFF, region_base + live_off[0] + 8); // off boundary
      free_live(0);
      send_req(1'b1, 32'd0, region_base + freed_off[freed_off.size() - 1]); // double
      send_req(1'b1, 32'd0, ALL_ONES);
      drain();
   endtask

   task automatic test_config_extremes();
      write_regs(64'h0000_1000_0000_0000, 64'd0, 64'd0);       // empty heap
      send_req(1'b0, 32'd20, 64'd0);
      send_req(1'b0, 32'd8000, 64'd0);
      drain();
      write_regs(64'h0000_1000_0000_0000, ALL_ONES, ALL_ONES);
      send_req(1'b0, 32'd1, 64'd0);
      send_req(1'b1, 32'd0, region_base + live_off[0]);        // slab base below heap
      drain();
      write_regs(64'hFFFF_FFFF_FFFF_0000, 64'd0, ALL_ONES);    // region wraps past zero
      for (int i = 0; i < 4; i++) send_req(1'b0, 32'd1 + 32'(i), 64'd0);
      free_live(live_off.size() - 1);
      drain();
      write_regs(64'h0000_0000_4000_0000, 64'h0000_0000_4000_0000,
                 64'h0000_0000_4004_0000);
   endtask

   task automatic random_item();
      int r, c, q;
      logic [31:0] size;
      r = $urandom_range(99);
      if (r < 45) begin
         q = $urandom_range(99);
         if (q < 3) size = 32'd0;
         else if (q < 6) size = $urandom_range(32'hFFFF_FFFF, 32'd16385);
         else if (q < 8) size = $urandom;
         else begin
            c = ($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(CLASSES - 1);
            size = $urandom_range(32'd32 << c, (c == 0) ? 32'd1 : (32'd16 << c) + 32'd1);
         end
         send_req(1'b0, size, {$urandom, $urandom});
      end else begin
         q = $urandom_range(99);
         if (q < 70 && live_off.size() != 0)
            free_live($urandom_range(live_off.size() - 1));
         else if (q < 80 && freed_off.size() != 0)
            send_req(1'b1, $urandom,
                     region_base + freed_off[$urandom_range(freed_off.size() - 1)]);
         else if (q < 88 && live_off.size() != 0)
            send_req(1'b1, $urandom, region_base
                     + live_off[$urandom_range(live_off.size() - 1)] + $urandom_range(15, 1));
         else if (q < 92)
            send_req(1'b1, $urandom, 64'd0);
         else
            send_req(1'b1, $urandom, {$urandom, $urandom});
      end
   endtask

   task automatic test_random();
      snd_idle = 26; rcv_idle = 61;
      repeat (330) random_item();
      drain();
      write_regs(64'h0000_1000_0000_0000, 64'd0, ALL_ONES);
      snd_idle = 61; rcv_idle = 26;
      repeat (330) random_item();
      drain();
      write_regs(64'h0000_1000_0000_0000, 64'h0000_1000_0000_0000, 64'h0000_1000_0010_0000);
      snd_idle = 0; rcv_idle = 0;
      repeat (330) random_item();
      drain();
   endtask

   task automatic test_backpressure();
      write_regs(64'h0000_1000_0000_0000, 64'd0, ALL_ONES);
      hold_left = 400;
      repeat (25) random_item();
      drain();
   endtask

   initial begin
      for (int s = 0; s < SLOTS; s++) begin
         slot_cls[s] = '0;
         slot_cnt[s] = 0;
      end
      claimed = 0;
      region_base = '0; heap_lo = '0; heap_hi = ALL_ONES;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_random();
      test_backpressure();
      $display("Sent %0d requests and checked %0d responses; %0d of %0d slabs claimed.",
               n_req, n_rsp, claimed, SLOTS);
      $display("Covered all size classes, frees, double frees, bad addresses and heap limits.");
      if (!failed) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end
endmodule
